// ===== hdl/two_class_frame_publisher_macros.svh =====
// assertion helpers for the frame publisher
`ifndef TWO_CLASS_FRAME_PUBLISHER_MACROS_SVH
`define TWO_CLASS_FRAME_PUBLISHER_MACROS_SVH
// clocked implication check, reset disables
`define TCFP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define TCFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hdl/tcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfp_pkg
// shared types and codes of the two-class frame publisher
// ----------------------------------------------------------------------------
`default_nettype none
package tcfp_pkg;
   localparam logic [1:0] CMD_PUSH_EVENT = 2'd0;
   localparam logic [1:0] CMD_PUSH_BULK  = 2'd1;
   localparam logic [1:0] CMD_DRAIN      = 2'd2;
   localparam logic [1:0] CMD_STAT       = 2'd3;

   localparam logic [2:0] KIND_QUEUED    = 3'd0;
   localparam logic [2:0] KIND_DROPPED   = 3'd1;
   localparam logic [2:0] KIND_DISPLACED = 3'd2;
   localparam logic [2:0] KIND_BYPASSED  = 3'd3;
   localparam logic [2:0] KIND_FRAME     = 3'd4;
   localparam logic [2:0] KIND_EMPTY     = 3'd5;
   localparam logic [2:0] KIND_STAT      = 3'd6;

   localparam logic REG_GATHER_LIMIT = 1'b0;
   localparam logic REG_BYPASS       = 1'b1;

   localparam int FRAME_W = 64;
   localparam int TIME_W  = 32;
   localparam int ENTRY_W = FRAME_W + TIME_W;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] frame;
      logic [31:0] now;
      logic [2:0]  stat_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] out_frame;
      logic        from_bulk;
      logic        last;
      logic [31:0] wait_time;
      logic [31:0] stat_value;
   } rsp_type;

   typedef struct packed {
      logic        index;
      logic [3:0]  data;
      logic        extra;
   } csr_type;
endpackage
`default_nettype wire

// ===== hdl/tcfp_if.sv =====
// ----------------------------------------------------------------------------
// tcfp_req_if / tcfp_rsp_if / tcfp_csr_if
// valid/ready channels of the frame publisher
// ----------------------------------------------------------------------------
`default_nettype none
interface tcfp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [63:0] frame;
   logic [31:0] now;
   logic [2:0]  stat_index;
   modport source (output valid, command, frame, now, stat_index, input ready);
   modport sink (input valid, command, frame, now, stat_index, output ready);
endinterface

interface tcfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [63:0] out_frame;
   logic        from_bulk;
   logic        last;
   logic [31:0] wait_time;
   logic [31:0] stat_value;
   modport source (output valid, kind, out_frame, from_bulk, last, wait_time,
                   stat_value, input ready);
   modport sink (input valid, kind, out_frame, from_bulk, last, wait_time,
                 stat_value, output ready);
endinterface

interface tcfp_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/two_class_frame_publisher.sv =====
// ----------------------------------------------------------------------------
// two_class_frame_publisher
// strict-priority event/bulk frame queues with gather drain and statistics
// ----------------------------------------------------------------------------
// Usage: words enter on req (command, frame, now, stat_index); results leave
// on rsp; csr index 0 writes gather_limit (clamped 1..GATHER_MAX), index 1
// writes bypass. A push or stat read is accepted in ST_IDLE, passes through
// ST_SETTLE while the ram read of the new head settles, and gives one result
// word. A drain gives n frame words, n up to gather_limit; the event queue
// wins when non-empty. Each frame pops the queue and the ram then returns the
// next head, so the drain passes through ST_OUT before the next frame, and
// ST_SETTLE follows the last frame. The result sits in an output register;
// when the receiver stalls the block holds and takes no new word.
// Reset empties both queues, clears statistics, sets gather_limit to 8 and
// bypass to 0; ram contents are left as they are, since only written entries
// are read.
// ----------------------------------------------------------------------------
`default_nettype none
module two_class_frame_publisher
   import tcfp_pkg::*;
#(
   parameter int EVENT_DEPTH = 64,
   parameter int BULK_DEPTH  = 128,
   parameter int GATHER_MAX  = 8
) (
   input wire logic    clock,
   input wire logic    reset,
   tcfp_req_if.sink    req,
   tcfp_rsp_if.source  rsp,
   tcfp_csr_if.sink    csr
);
`include "two_class_frame_publisher_macros.svh"
   localparam int EW = $clog2(EVENT_DEPTH) + 1;
   localparam int BW = $clog2(BULK_DEPTH) + 1;
   localparam int GW = $clog2(GATHER_MAX + 1);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETTLE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  limit_ff, limit_in;
   logic        bypass_ff, bypass_in;
   logic [31:0] stat_ff [8];
   logic [31:0] stat_in [8];
   rsp_type     out_ff, out_in;
   logic        ovalid_ff, ovalid_in;
   logic        bulk_ff, bulk_in;
   logic [GW-1:0] left_ff, left_in;
   logic [31:0] now_ff, now_in, wait_ff, wait_in;
   logic        first_ff, first_in;

   logic                 ev_push, ev_pop, bk_push, bk_pop;
   logic [ENTRY_W-1:0]   ev_head, bk_head, head;
   logic [EW-1:0]        ev_count;
   logic [BW-1:0]        bk_count;
   logic                 take, bk_full;
   logic [31:0]          wt;
   logic [3:0]           wlim;

   assign take = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign csr.ready = 1'b1;
   assign bk_full = bk_count == BW'(BULK_DEPTH);
   assign head = bulk_ff ? bk_head : ev_head;

   function automatic logic [3:0] clamp(input logic [3:0] v);
      if (v == 4'd0) return 4'd1;
      if ({28'd0, v} > 32'(GATHER_MAX)) return 4'(GATHER_MAX);
      return v;
   endfunction

   always_comb begin
      state_in  = state_ff;
      limit_in  = limit_ff;
      bypass_in = bypass_ff;
      stat_in   = stat_ff;
      out_in    = out_ff;
      ovalid_in = ovalid_ff;
      bulk_in   = bulk_ff;
      left_in   = left_ff;
      now_in    = now_ff;
      wait_in   = wait_ff;
      first_in  = first_ff;
      ev_push = 1'b0; ev_pop = 1'b0; bk_push = 1'b0; bk_pop = 1'b0;
      wt = 32'd0;
      wlim = 4'd0;
      if (ovalid_ff && rsp.ready) ovalid_in = 1'b0;
      if (csr.valid) begin
         if (csr.index == 8'(REG_GATHER_LIMIT)) limit_in = clamp(csr.data[3:0]);
         if (csr.index == 8'(REG_BYPASS)) bypass_in = csr.data[0];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               out_in = '0;
               out_in.last = 1'b1;
               state_in = ST_SETTLE;
               case (req.command) inside
                  CMD_PUSH_EVENT, CMD_PUSH_BULK: begin
                     ovalid_in = 1'b1;
                     if (bypass_ff) begin
                        out_in.kind = KIND_BYPASSED;
                        out_in.out_frame = req.frame;
                     end else if (req.command == CMD_PUSH_EVENT) begin
                        if (ev_count == EW'(EVENT_DEPTH)) begin
                           out_in.kind = KIND_DROPPED;
                           stat_in[2] = stat_ff[2] + 32'd1;
                        end else begin
                           ev_push = 1'b1;
                           out_in.kind = KIND_QUEUED;
                           if (32'(ev_count) + 32'd1 > stat_ff[0])
                              stat_in[0] = 32'(ev_count) + 32'd1;
                        end
                     end else begin
                        bk_push = 1'b1;
                        if (bk_full) begin
                           bk_pop = 1'b1;
                           out_in.kind = KIND_DISPLACED;
                           stat_in[3] = stat_ff[3] + 32'd1;
                        end else begin
                           out_in.kind = KIND_QUEUED;
                           if (32'(bk_count) + 32'd1 > stat_ff[1])
                              stat_in[1] = 32'(bk_count) + 32'd1;
                        end
                     end
                  end
                  CMD_STAT: begin
                     ovalid_in = 1'b1;
                     out_in.kind = KIND_STAT;
                     out_in.stat_value = stat_ff[req.stat_index];
                  end
                  default: begin
                     if (bypass_ff || (ev_count == '0 && bk_count == '0)) begin
                        ovalid_in = 1'b1;
                        out_in.kind = KIND_EMPTY;
                     end else begin
                        bulk_in = ev_count == '0;
                        now_in = req.now;
                        first_in = 1'b1;
                        wlim = limit_ff;
                        if (ev_count == '0) begin
                           if (32'(bk_count) < 32'(wlim)) wlim = 4'(bk_count);
                        end else begin
                           if (32'(ev_count) < 32'(wlim)) wlim = 4'(ev_count);
                        end
                        left_in = GW'(wlim);
                        stat_in[6] = stat_ff[6] + 32'd1;
                        stat_in[7] = stat_ff[7] + 32'(wlim);
                        state_in = ST_DRAIN;
                     end
                  end
               endcase
            end
         end
         ST_SETTLE: state_in = ST_IDLE;
         ST_DRAIN: begin
            // head word of the chosen queue is valid here
            if (!ovalid_ff || rsp.ready) begin
               wt = first_ff ? now_ff - head[31:0] : wait_ff;
               if (first_ff) begin
                  stat_in[4] = wt;
                  if (wt > stat_ff[5]) stat_in[5] = wt;
               end
               wait_in   = wt;
               first_in  = 1'b0;
               ovalid_in = 1'b1;
               out_in.kind = KIND_FRAME;
               out_in.out_frame = head[ENTRY_W-1:TIME_W];
               out_in.from_bulk = bulk_ff;
               out_in.wait_time = wt;
               out_in.stat_value = 32'd0;
               out_in.last = left_ff == GW'(1);
               left_in = left_ff - 1'b1;
               if (bulk_ff) bk_pop = 1'b1; else ev_pop = 1'b1;
               state_in = (left_ff == GW'(1)) ? ST_SETTLE : ST_OUT;
            end
         end
         ST_OUT: state_in = ST_DRAIN;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         limit_ff  <= clamp(4'd8);
         bypass_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) stat_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         limit_ff  <= limit_in;
         bypass_ff <= bypass_in;
         ovalid_ff <= ovalid_in;
         stat_ff   <= stat_in;
      end
      out_ff   <= out_in;
      bulk_ff  <= bulk_in;
      left_ff  <= left_in;
      now_ff   <= now_in;
      wait_ff  <= wait_in;
      first_ff <= first_in;
   end

   tcfp_fifo_ctl #(.DEPTH(EVENT_DEPTH)) u_event (
      .clock (clock), .reset (reset), .push (ev_push), .pop (ev_pop),
      .push_data ({req.frame, req.now}), .head_data (ev_head), .count (ev_count)
   );

   tcfp_fifo_ctl #(.DEPTH(BULK_DEPTH)) u_bulk (
      .clock (clock), .reset (reset), .push (bk_push), .pop (bk_pop),
      .push_data ({req.frame, req.now}), .head_data (bk_head), .count (bk_count)
   );

   assign rsp.valid      = ovalid_ff;
   assign rsp.kind       = out_ff.kind;
   assign rsp.out_frame  = out_ff.out_frame;
   assign rsp.from_bulk  = out_ff.from_bulk;
   assign rsp.last       = out_ff.last;
   assign rsp.wait_time  = out_ff.wait_time;
   assign rsp.stat_value = out_ff.stat_value;

   `TCFP_ASSERT(a_no_push_pop_event, clock, reset, !(ev_push && ev_pop), "event push and pop together")
   `TCFP_ASSERT(a_event_bound, clock, reset, ev_count <= EW'(EVENT_DEPTH), "event count overflow")
   `TCFP_ASSERT(a_drain_nonempty, clock, reset, (state_ff == ST_DRAIN) |-> (bulk_ff ? bk_count != '0 : ev_count != '0), "drain from empty queue")
endmodule
`default_nettype wire

// ===== hdl/tcfp_ram.sv =====
// ----------------------------------------------------------------------------
// tcfp_ram
// single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module tcfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/tcfp_fifo_ctl.sv =====
// ----------------------------------------------------------------------------
// tcfp_fifo_ctl
// head/tail/count of one queue around a ram of frames and stamps
// ----------------------------------------------------------------------------
`default_nettype none
module tcfp_fifo_ctl
   import tcfp_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic                   pop,
   input  wire logic [ENTRY_W-1:0]     push_data,
   output logic      [ENTRY_W-1:0]     head_data,
   output logic      [$clog2(DEPTH):0] count
);
   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [AW:0]   count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == LAST_ADDR) ? '0 : tail_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // read address runs one ahead so head data is ready next cycle
   tcfp_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (push_data),
      .rd_addr (head_in),
      .rd_data (head_data)
   );

   assign count = count_ff;
endmodule
`default_nettype wire

// ===== bench/two_class_frame_publisher_checker.sv =====
// ----------------------------------------------------------------------------
// two_class_frame_publisher_checker
// watches the req, rsp and csr channels of the frame publisher, keeps its own
// copy of both queues, the statistics and the registers, predicts the result
// words of each accepted request and compares them in order with rsp
// ----------------------------------------------------------------------------
`default_nettype none
module two_class_frame_publisher_checker
   import tcfp_pkg::*;
#(
   parameter int EVENT_DEPTH = 64,
   parameter int BULK_DEPTH  = 128,
   parameter int GATHER_MAX  = 8
) (
   input wire logic clock,
   input wire logic reset,
   tcfp_req_if      req,
   tcfp_rsp_if      rsp,
   tcfp_csr_if      csr,
   output int       fail_count,
   output int       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAT_EVENT_HWM   = 0;
   localparam int STAT_BULK_HWM    = 1;
   localparam int STAT_EVENT_DROPS = 2;
   localparam int STAT_BULK_DISPL  = 3;
   localparam int STAT_LAST_WAIT   = 4;
   localparam int STAT_MAX_WAIT    = 5;
   localparam int STAT_GATHERS     = 6;
   localparam int STAT_GATHERED    = 7;

   typedef struct {
      logic [63:0] handle;
      logic [31:0] stamp;
   } queued_frame_type;

   queued_frame_type event_q[$];
   queued_frame_type bulk_q[$];
   logic [31:0]   stats[8];
   int unsigned   gather_limit;
   logic          bypass;
   rsp_type       expected_words[$];
   int            mismatches;

   function automatic rsp_type make_word(logic [2:0] kind, logic [63:0] fr = '0,
                                         logic fb = 1'b0, logic lst = 1'b1,
                                         logic [31:0] wt = '0,
                                         logic [31:0] sv = '0);
      rsp_type w;
      w.kind = kind;
      w.out_frame = fr;
      w.from_bulk = fb;
      w.last = lst;
      w.wait_time = wt;
      w.stat_value = sv;
      return w;
   endfunction

   task automatic predict_request(logic [1:0] cmd, logic [63:0] fr, logic [31:0] now,
                                  logic [2:0] sidx);
      queued_frame_type e;
      int unsigned   n;
      logic          use_bulk;
      logic [31:0]   wt;
      e.handle = fr;
      e.stamp = now;
      if ((cmd == CMD_PUSH_EVENT || cmd == CMD_PUSH_BULK) && bypass) begin
         expected_words.push_back(make_word(KIND_BYPASSED, fr));
      end else if (cmd == CMD_PUSH_EVENT) begin
         if (event_q.size() >= EVENT_DEPTH) begin
            stats[STAT_EVENT_DROPS]++;
            expected_words.push_back(make_word(KIND_DROPPED));
         end else begin
            event_q.push_back(e);
            if (event_q.size() > stats[STAT_EVENT_HWM]) stats[STAT_EVENT_HWM] = event_q.size();
            expected_words.push_back(make_word(KIND_QUEUED));
         end
      end else if (cmd == CMD_PUSH_BULK) begin
         if (bulk_q.size() >= BULK_DEPTH) begin
            void'(bulk_q.pop_front());
            stats[STAT_BULK_DISPL]++;
            expected_words.push_back(make_word(KIND_DISPLACED));
         end else begin
            expected_words.push_back(make_word(KIND_QUEUED));
         end
         bulk_q.push_back(e);
         if (bulk_q.size() > stats[STAT_BULK_HWM]) stats[STAT_BULK_HWM] = bulk_q.size();
      end else if (cmd == CMD_STAT) begin
         expected_words.push_back(make_word(KIND_STAT, '0, 1'b0, 1'b1, '0, stats[sidx]));
      end else if (bypass || (event_q.size() == 0 && bulk_q.size() == 0)) begin
         expected_words.push_back(make_word(KIND_EMPTY));
      end else begin
         use_bulk = (event_q.size() == 0);
         n = use_bulk ? bulk_q.size() : event_q.size();
         if (n > gather_limit) n = gather_limit;
         wt = now - (use_bulk ? bulk_q[0].stamp : event_q[0].stamp);
         for (int k = 0; k < n; k++) begin
            e = use_bulk ? bulk_q.pop_front() : event_q.pop_front();
            expected_words.push_back(make_word(KIND_FRAME, e.handle, use_bulk,
                                               (k + 1 == n), wt));
         end
         stats[STAT_LAST_WAIT] = wt;
         if (wt > stats[STAT_MAX_WAIT]) stats[STAT_MAX_WAIT] = wt;
         stats[STAT_GATHERS]++;
         stats[STAT_GATHERED] += n;
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         event_q.delete();
         bulk_q.delete();
         expected_words.delete();
         foreach (stats[i]) stats[i] = '0;
         gather_limit = GATHER_MAX;
         bypass = 1'b0;
         mismatches = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == 8'(REG_GATHER_LIMIT)) begin
               gather_limit = csr.data[3:0];
               if (gather_limit < 1) gather_limit = 1;
               if (gather_limit > GATHER_MAX) gather_limit = GATHER_MAX;
            end else if (csr.index == 8'(REG_BYPASS)) begin
               bypass = csr.data[0];
            end
         end
         if (req.valid && req.ready)
            predict_request(req.command, req.frame, req.now, req.stat_index);
         if (rsp.valid && rsp.ready) begin
            got.kind = rsp.kind;
            got.out_frame = rsp.out_frame;
            got.from_bulk = rsp.from_bulk;
            got.last = rsp.last;
            got.wait_time = rsp.wait_time;
            got.stat_value = rsp.stat_value;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rsp word: kind %0d frame %h", got.kind, got.out_frame);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rsp mismatch: expected kind %0d frame %h bulk %b last %b wait %h stat %h, got kind %0d frame %h bulk %b last %b wait %h stat %h",
                              want.kind, want.out_frame, want.from_bulk, want.last,
                              want.wait_time, want.stat_value, got.kind, got.out_frame,
                              got.from_bulk, got.last, got.wait_time, got.stat_value);
               end
            end
         end
      end
      fail_count = mismatches;
      pending = expected_words.size();
   end
endmodule
`default_nettype wire

// ===== bench/two_class_frame_publisher_tb.sv =====
// ----------------------------------------------------------------------------
// two_class_frame_publisher_tb
// drives directed and random request words and register writes into the
// frame publisher with random gaps and a long rsp hold-off, and reports the
// verdict from the checker's failure and pending counts
// ----------------------------------------------------------------------------
`default_nettype none
module two_class_frame_publisher_tb;
   import tcfp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          HOLD_CYCLES    = 400;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam logic [7:0]  REG_UNUSED     = 8'd2;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   words_sent;
   int   idle_cycles;
   logic hold_go;
   logic [31:0] tnow;

   tcfp_req_if req_ch();
   tcfp_rsp_if rsp_ch();
   tcfp_csr_if csr_ch();

   two_class_frame_publisher i_dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch)
   );

   two_class_frame_publisher_checker i_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // no random gaps or rsp stalls through this window
   function automatic logic quiet();
      return words_sent >= 250 && words_sent < 300;
   endfunction

   task automatic send_word(logic [1:0] cmd, logic [63:0] fr, logic [31:0] now,
                            logic [2:0] sidx);
      if (!quiet() && $urandom_range(99) < 9) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.command = cmd;
      req_ch.frame = fr;
      req_ch.now = now;
      req_ch.stat_index = sidx;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [31:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data = data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // all results in and the block quiet before a register write
   task automatic settle();
      req_ch.valid = 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (10) @(negedge clock);
   endtask

   task automatic random_word(int pe, int pb, int pd);
      int r;
      r = $urandom_range(99);
      if ($urandom_range(19) == 0) tnow = $urandom;
      else tnow += $urandom_range(0, 50);
      if (r < pe)
         send_word(CMD_PUSH_EVENT, {$urandom, $urandom}, tnow, 3'($urandom));
      else if (r < pe + pb)
         send_word(CMD_PUSH_BULK, {$urandom, $urandom}, tnow, 3'($urandom));
      else if (r < pe + pb + pd)
         send_word(CMD_DRAIN, {$urandom, $urandom}, tnow, 3'($urandom));
      else
         send_word(CMD_STAT, {$urandom, $urandom}, tnow, 3'($urandom));
   endtask

   task automatic random_phase(int count, int pe, int pb, int pd);
      for (int i = 0; i < count; i++) random_word(pe, pb, pd);
   endtask

   // rsp side: random stalls, one long hold-off while requests keep coming
   initial begin
      logic hold_done;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ch.ready = quiet() ? 1'b1 : ($urandom_range(99) >= 9);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      hold_go = 1'b0;
      words_sent = 0;
      tnow = '0;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_STAT;
      req_ch.frame = '0;
      req_ch.now = '0;
      req_ch.stat_index = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed: empty drain, extremes, both queues, every statistic
      send_word(CMD_DRAIN, '0, 32'd0, 3'd0);
      send_word(CMD_PUSH_EVENT, '0, 32'd0, 3'd0);
      send_word(CMD_PUSH_EVENT, '1, '1, '1);
      send_word(CMD_PUSH_BULK, '1, 32'd5, 3'd0);
      send_word(CMD_PUSH_BULK, '0, '1, 3'd0);
      send_word(CMD_DRAIN, '0, 32'd100, 3'd0);
      send_word(CMD_DRAIN, '1, 32'd3, '1);
      send_word(CMD_DRAIN, '0, 32'd7, 3'd0);
      for (int s = 0; s < 8; s++) send_word(CMD_STAT, '0, 32'd0, 3'(s));
      settle();
      write_reg(8'(REG_BYPASS), 32'd1);
      send_word(CMD_PUSH_EVENT, 64'h0123_4567_89ab_cdef, 32'd9, 3'd0);
      send_word(CMD_PUSH_BULK, 64'hfedc_ba98_7654_3210, 32'd9, 3'd0);
      send_word(CMD_DRAIN, '0, 32'd9, 3'd0);
      settle();
      write_reg(8'(REG_BYPASS), 32'd0);
      write_reg(8'(REG_GATHER_LIMIT), 32'd0);
      random_phase(25, 40, 30, 20);

      // fill both queues past full, rsp held off partway
      settle();
      write_reg(8'(REG_GATHER_LIMIT), 32'hffff_ff0f);
      for (int i = 0; i < 70; i++) begin
         if (i == 20) hold_go = 1'b1;
         tnow += $urandom_range(0, 20);
         send_word(CMD_PUSH_EVENT, {$urandom, $urandom}, tnow, 3'($urandom));
      end
      for (int i = 0; i < 135; i++) begin
         tnow += $urandom_range(0, 20);
         send_word(CMD_PUSH_BULK, {$urandom, $urandom}, tnow, 3'($urandom));
      end
      for (int s = 0; s < 4; s++) send_word(CMD_STAT, '0, tnow, 3'(s));

      settle();
      write_reg(8'(REG_GATHER_LIMIT), {28'($urandom), 4'($urandom_range(2, 7))});
      random_phase(30, 5, 5, 80);

      settle();
      write_reg(8'(REG_BYPASS), {31'($urandom), 1'b1});
      write_reg(REG_UNUSED, $urandom);
      random_phase(12, 35, 35, 20);

      settle();
      write_reg(8'(REG_BYPASS), {31'($urandom), 1'b0});
      write_reg(8'(REG_GATHER_LIMIT), 32'd8);
      random_phase(25, 30, 30, 25);

      settle();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
